### rtl/key_range_intersect_top_defines.svh
// Assertion macros used by the checker file of the key range block.
`ifndef KEY_RANGE_INTERSECT_TOP_DEFINES_SVH
`define KEY_RANGE_INTERSECT_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define KRX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("krx: implication failed");

// Next-cycle implication, masked while reset is held.
`define KRX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("krx: next-cycle implication failed");

`endif

### rtl/krx_pkg.sv
// ----------------------------------------------------------------------------
// krx_pkg
// Types and codes shared by the key range intersect block.
// ----------------------------------------------------------------------------
package krx_pkg;

    localparam int KEY_W = 32;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_LEAF  = 2'd1,
        KIND_OR    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        OP_EQ  = 3'd0,
        OP_NEQ = 3'd1,
        OP_GT  = 3'd2,
        OP_LT  = 3'd3,
        OP_GE  = 3'd4,
        OP_LE  = 3'd5
    } t_op;

    typedef struct packed {
        logic [1:0]       kind;
        logic             on_key_column;
        logic [2:0]       compare_op;
        logic [KEY_W-1:0] operand_value;
    } t_item;

    typedef struct packed {
        logic             narrowed;
        logic             point;
        logic [KEY_W-1:0] pin_key;
        logic [KEY_W-1:0] lower;
        logic [KEY_W-1:0] upper;
        logic             empty;
    } t_result;

endpackage

### rtl/krx_ifs.sv
// ----------------------------------------------------------------------------
// krx_ifs
// Request channels of the key range block: predicate items in, ranges out.
// ----------------------------------------------------------------------------
interface krx_item_if import krx_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic             on_key_column;
    logic [2:0]       compare_op;
    logic [KEY_W-1:0] operand_value;

    modport source (output valid, kind, on_key_column, compare_op, operand_value,
                    input ready);
    modport sink   (input valid, kind, on_key_column, compare_op, operand_value,
                    output ready);
endinterface

interface krx_result_if import krx_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             out_narrowed;
    logic             out_point;
    logic [KEY_W-1:0] out_pin_key;
    logic [KEY_W-1:0] out_lower;
    logic [KEY_W-1:0] out_upper;
    logic             out_empty;

    modport source (output valid, out_narrowed, out_point, out_pin_key, out_lower,
                    out_upper, out_empty, input ready);
    modport sink   (input valid, out_narrowed, out_point, out_pin_key, out_lower,
                    out_upper, out_empty, output ready);
endinterface

### rtl/krx_in_reg.sv
// ----------------------------------------------------------------------------
// krx_in_reg
// Input register: holds one accepted predicate item until the core takes it.
// ----------------------------------------------------------------------------
module krx_in_reg import krx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/krx_core.sv
// ----------------------------------------------------------------------------
// krx_core
// Range state and its combinational next-state update for one predicate item.
// ----------------------------------------------------------------------------
module krx_core import krx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic             r_narrowed;
    logic             r_point;
    logic [KEY_W-1:0] r_pin_key;
    logic [KEY_W-1:0] r_lower;
    logic [KEY_W-1:0] r_upper;
    logic             r_empty;

    logic             n_narrowed;
    logic             n_point;
    logic [KEY_W-1:0] n_pin_key;
    logic [KEY_W-1:0] n_lower;
    logic [KEY_W-1:0] n_upper;
    logic             n_empty;

    logic [KEY_W-1:0] w_v;
    logic [KEY_W-1:0] w_v_inc;
    logic [KEY_W-1:0] w_v_dec;

    assign w_v     = i_item.operand_value;
    assign w_v_inc = w_v + KEY_W'(1);
    assign w_v_dec = w_v - KEY_W'(1);

    always_comb begin
        n_narrowed = r_narrowed;
        n_point    = r_point;
        n_pin_key  = r_pin_key;
        n_lower    = r_lower;
        n_upper    = r_upper;
        n_empty    = r_empty;
        case (i_item.kind)
            KIND_START: begin
                n_narrowed = 1'b0;
                n_point    = 1'b0;
                n_pin_key  = '0;
                n_lower    = '0;
                n_upper    = KEY_MAX;
                n_empty    = 1'b0;
            end
            KIND_LEAF: begin
                if (!r_empty && i_item.on_key_column) begin
                    n_narrowed = 1'b1;
                    case (i_item.compare_op)
                        OP_EQ: begin
                            if ((r_point && (r_pin_key != w_v)) ||
                                (w_v < r_lower) || (w_v > r_upper)) begin
                                n_empty = 1'b1;
                            end
                            n_point   = 1'b1;
                            n_pin_key = w_v;
                            n_lower   = w_v;
                            n_upper   = w_v;
                        end
                        OP_GE: begin
                            if (w_v > r_lower) begin
                                n_lower = w_v;
                            end
                        end
                        OP_GT: begin
                            if (w_v == KEY_MAX) begin
                                n_empty = 1'b1;
                            end else if (w_v_inc > r_lower) begin
                                n_lower = w_v_inc;
                            end
                        end
                        OP_LE: begin
                            if (w_v < r_upper) begin
                                n_upper = w_v;
                            end
                        end
                        OP_LT: begin
                            if (w_v == '0) begin
                                n_empty = 1'b1;
                            end else if (w_v_dec < r_upper) begin
                                n_upper = w_v_dec;
                            end
                        end
                        default: begin
                            // not-equal and spare codes only mark the range narrowed
                        end
                    endcase
                    if (n_lower > n_upper) begin
                        n_empty = 1'b1;
                    end
                end
            end
            KIND_OR: begin
                if (!r_empty) begin
                    n_narrowed = 1'b0;
                    n_point    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrowed <= 1'b0;
            r_point    <= 1'b0;
            r_pin_key  <= '0;
            r_lower    <= '0;
            r_upper    <= KEY_MAX;
            r_empty    <= 1'b0;
        end else if (i_fire) begin
            r_narrowed <= n_narrowed;
            r_point    <= n_point;
            r_pin_key  <= n_pin_key;
            r_lower    <= n_lower;
            r_upper    <= n_upper;
            r_empty    <= n_empty;
        end
    end

    always_comb begin
        o_result.narrowed = n_narrowed;
        o_result.point    = n_point;
        o_result.pin_key  = n_pin_key;
        o_result.lower    = n_lower;
        o_result.upper    = n_upper;
        o_result.empty    = n_empty;
    end

endmodule

### rtl/krx_out_reg.sv
// ----------------------------------------------------------------------------
// krx_out_reg
// Result register: holds the range of the last item until the receiver takes it.
// ----------------------------------------------------------------------------
module krx_out_reg import krx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_up_valid,
    output logic    o_up_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;
    logic    w_load;

    assign o_up_ready = !r_valid || i_ready;
    assign w_load     = i_up_valid && o_up_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### rtl/key_range_intersect_top.sv
// ----------------------------------------------------------------------------
// key_range_intersect_top
// Usage:
//   i_item carries predicate requests (start, comparison leaf, OR node);
//   o_result returns one range request per item: narrowed and point flags,
//   pinned key, inclusive lower and upper bounds and the empty flag.
//   Both channels move a request when valid and ready are high together.
// Path: an accepted request is held in the input register, and its range
//   is then loaded into the result register and shown on o_result.
// Throughput: one request per cycle while o_result is not held; the range
//   update is compares, an increment and a decrement between the registers.
// Reset: i_rst_n low at a clock edge empties both registers and restores
//   the range to [0, all ones] with every flag clear, as a start request does.
// Stall: while o_result is held, the result register and the input register
//   each keep one request; i_item.ready drops once both are full.
// ----------------------------------------------------------------------------
module key_range_intersect_top import krx_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    krx_item_if.sink      i_item,
    krx_result_if.source  o_result
);

    t_item   w_in_item;
    t_item   w_core_item;
    t_result w_core_result;
    t_result w_out_result;
    logic    w_mid_valid;
    logic    w_mid_ready;
    logic    w_fire;

    assign w_in_item.kind          = i_item.kind;
    assign w_in_item.on_key_column = i_item.on_key_column;
    assign w_in_item.compare_op    = i_item.compare_op;
    assign w_in_item.operand_value = i_item.operand_value;

    krx_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_item  (w_in_item),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_item  (w_core_item)
    );

    assign w_fire = w_mid_valid && w_mid_ready;

    krx_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_core_item),
        .o_result (w_core_result)
    );

    krx_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (w_mid_valid),
        .o_up_ready (w_mid_ready),
        .i_result   (w_core_result),
        .o_valid    (o_result.valid),
        .i_ready    (o_result.ready),
        .o_result   (w_out_result)
    );

    assign o_result.out_narrowed = w_out_result.narrowed;
    assign o_result.out_point    = w_out_result.point;
    assign o_result.out_pin_key  = w_out_result.pin_key;
    assign o_result.out_lower    = w_out_result.lower;
    assign o_result.out_upper    = w_out_result.upper;
    assign o_result.out_empty    = w_out_result.empty;

endmodule

### rtl/krx_checker.sv
// ----------------------------------------------------------------------------
// krx_checker
// Port-level checks on the result channel of the key range block.
// ----------------------------------------------------------------------------
`include "key_range_intersect_top_defines.svh"

module krx_checker import krx_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic             i_narrowed,
    input logic             i_point,
    input logic [KEY_W-1:0] i_pin_key,
    input logic [KEY_W-1:0] i_lower,
    input logic [KEY_W-1:0] i_upper,
    input logic             i_empty
);

    logic w_live_point;
    logic w_pinned;

    assign w_live_point = i_valid && i_point && !i_empty;
    assign w_pinned     = (i_lower == i_pin_key) && (i_upper == i_pin_key);

    // a held result stays offered
    `KRX_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, i_valid && !i_ready, i_valid)

    // a live range never has crossed bounds
    `KRX_ASSERT_IMP(a_bounds_order, i_clk, i_rst_n, i_valid && !i_empty, i_lower <= i_upper)

    // a live point lookup pins both bounds to the key
    `KRX_ASSERT_IMP(a_point_pins, i_clk, i_rst_n, w_live_point, w_pinned)

    // point lookups only come from narrowing leaves
    `KRX_ASSERT_IMP(a_point_narrowed, i_clk, i_rst_n, i_valid && i_point, i_narrowed)

endmodule

bind key_range_intersect_top krx_checker u_krx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_result.valid),
    .i_ready    (o_result.ready),
    .i_narrowed (o_result.out_narrowed),
    .i_point    (o_result.out_point),
    .i_pin_key  (o_result.out_pin_key),
    .i_lower    (o_result.out_lower),
    .i_upper    (o_result.out_upper),
    .i_empty    (o_result.out_empty)
);

### tb/sv/tb_key_range_intersect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_range_intersect_top
// Drives predicate requests into the key range block and checks every range
// request that comes back against a cycle-free predictor kept in step with
// the accepted inputs. Directed edge cases first, then a long output stall,
// then random predicate sequences under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_key_range_intersect_top;
    import krx_pkg::*;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         HOLD_CYCLES   = 120;
    localparam int         SETTLE_CYCLES = 8;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam logic [2:0] OP_SPARE_6    = 3'd6;
    localparam logic [2:0] OP_SPARE_7    = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic rx_hold = 1'b0;
    int   send_gap_pct = 0;
    int   stall_pct = 0;
    int   mismatches = 0;
    int   cycle_count = 0;
    event hold_go;

    // predicted range state, updated at each accepted request
    logic             k_narrowed = 1'b0;
    logic             k_point = 1'b0;
    logic [KEY_W-1:0] k_pin_key = '0;
    logic [KEY_W-1:0] k_lower = '0;
    logic [KEY_W-1:0] k_upper = KEY_MAX;
    logic             k_empty = 1'b0;

    t_result expected_ranges[$];

    krx_item_if   item_ch ();
    krx_result_if result_ch ();

    key_range_intersect_top dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch.sink),
        .o_result (result_ch.source)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        result_ch.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    always begin
        @(hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic narrow_range(input t_item req, output t_result r);
        logic [KEY_W-1:0] v;
        v = req.operand_value;
        case (req.kind)
            KIND_START: begin
                k_narrowed = 1'b0;
                k_point    = 1'b0;
                k_pin_key  = '0;
                k_lower    = '0;
                k_upper    = KEY_MAX;
                k_empty    = 1'b0;
            end
            KIND_LEAF: begin
                if (!k_empty && req.on_key_column) begin
                    k_narrowed = 1'b1;
                    case (req.compare_op)
                        OP_EQ: begin
                            if (k_point && k_pin_key != v) k_empty = 1'b1;
                            k_point   = 1'b1;
                            k_pin_key = v;
                            if (v < k_lower || v > k_upper) k_empty = 1'b1;
                            k_lower = v;
                            k_upper = v;
                        end
                        OP_GE: if (v > k_lower) k_lower = v;
                        OP_GT: begin
                            if (v == KEY_MAX) k_empty = 1'b1;
                            else if (v + 1'b1 > k_lower) k_lower = v + 1'b1;
                        end
                        OP_LE: if (v < k_upper) k_upper = v;
                        OP_LT: begin
                            if (v == '0) k_empty = 1'b1;
                            else if (v - 1'b1 < k_upper) k_upper = v - 1'b1;
                        end
                        default: ;  // neq and spare codes: flag only
                    endcase
                    if (k_lower > k_upper) k_empty = 1'b1;
                end
            end
            KIND_OR: begin
                if (!k_empty) begin
                    k_narrowed = 1'b0;
                    k_point    = 1'b0;
                end
            end
            default: ;
        endcase
        r.narrowed = k_narrowed;
        r.point    = k_point;
        r.pin_key  = k_pin_key;
        r.lower    = k_lower;
        r.upper    = k_upper;
        r.empty    = k_empty;
    endtask

    task automatic check_field(input string field, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] seen);
        if (seen !== want) begin
            mismatches++;
            $error("%s: expected %0h, got %0h", field, want, seen);
        end
    endtask

    // monitor: predict on accepted input, compare on accepted output
    always @(posedge clk) begin : range_monitor
        t_item   in_req;
        t_result want;
        if (rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                in_req.kind          = item_ch.kind;
                in_req.on_key_column = item_ch.on_key_column;
                in_req.compare_op    = item_ch.compare_op;
                in_req.operand_value = item_ch.operand_value;
                narrow_range(in_req, want);
                expected_ranges.push_back(want);
            end
            if (result_ch.valid && result_ch.ready) begin
                if (expected_ranges.size() == 0) begin
                    mismatches++;
                    $error("range result with no request outstanding");
                end else begin
                    want = expected_ranges.pop_front();
                    check_field("out_narrowed", KEY_W'(want.narrowed),
                                KEY_W'(result_ch.out_narrowed));
                    check_field("out_point", KEY_W'(want.point),
                                KEY_W'(result_ch.out_point));
                    check_field("out_pin_key", want.pin_key, result_ch.out_pin_key);
                    check_field("out_lower", want.lower, result_ch.out_lower);
                    check_field("out_upper", want.upper, result_ch.out_upper);
                    check_field("out_empty", KEY_W'(want.empty),
                                KEY_W'(result_ch.out_empty));
                end
            end
        end
    end

    function automatic t_item mk_req(input logic [1:0] kind, input logic on_key,
                                     input logic [2:0] op, input logic [KEY_W-1:0] v);
        t_item r;
        r.kind          = kind;
        r.on_key_column = on_key;
        r.compare_op    = op;
        r.operand_value = v;
        return r;
    endfunction

    // valid stays high after acceptance; only lowered at the start of a gap
    task automatic send_request(input t_item req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct) gap++;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.kind          <= req.kind;
        item_ch.on_key_column <= req.on_key_column;
        item_ch.compare_op    <= req.compare_op;
        item_ch.operand_value <= req.operand_value;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic wait_all_results();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_ranges.size() != 0);
    endtask

    function automatic logic [KEY_W-1:0] pick_window_base();
        case ($urandom_range(3))
            0:       return '0;
            1:       return KEY_MAX - 63;
            default: return $urandom_range(32'hFFFF_FFBF);
        endcase
    endfunction

    // one item of a predicate body; values mostly near base so ranges survive
    function automatic t_item pick_request(input logic [KEY_W-1:0] base);
        int               sel;
        logic [2:0]       op;
        logic [2:0]       any_op;
        logic             on_key;
        logic [KEY_W-1:0] v;
        sel    = $urandom_range(99);
        v      = ($urandom_range(7) == 0) ? $urandom : base + $urandom_range(63);
        op     = ($urandom_range(19) == 0) ? 3'($urandom_range(OP_SPARE_7, OP_SPARE_6))
                                           : 3'($urandom_range(OP_LE));
        any_op = 3'($urandom_range(7));
        on_key = 1'($urandom_range(1));
        if (sel < 6)       return mk_req(KIND_OR, on_key, any_op, v);
        else if (sel < 9)  return mk_req(KIND_UNUSED, on_key, any_op, v);
        else if (sel < 20) return mk_req(KIND_LEAF, 1'b0, op, v);
        else               return mk_req(KIND_LEAF, 1'b1, op, v);
    endfunction

    task automatic test_directed();
        send_gap_pct = 0;
        stall_pct    = 0;
        send_request(mk_req(KIND_START, 1'b0, OP_EQ, '0));
        send_request(mk_req(KIND_LEAF, 1'b0, OP_EQ, 32'd5));        // off key column
        send_request(mk_req(KIND_LEAF, 1'b1, OP_GE, '0));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_GT, 32'd10));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_LE, KEY_MAX));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_LT, 32'd1000));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_NEQ, 32'd500));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_SPARE_6, 32'd1));   // spare ops act as neq
        send_request(mk_req(KIND_LEAF, 1'b1, OP_SPARE_7, KEY_MAX));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_EQ, 32'd600));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_EQ, 32'd600));      // same point again
        send_request(mk_req(KIND_OR, 1'b1, OP_LE, KEY_MAX));
        send_request(mk_req(KIND_UNUSED, 1'b1, OP_SPARE_7, KEY_MAX));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_EQ, 32'd700));      // outside bounds
        send_request(mk_req(KIND_LEAF, 1'b1, OP_GE, '0));           // frozen
        send_request(mk_req(KIND_OR, 1'b0, OP_EQ, '0));             // frozen
        send_request(mk_req(KIND_START, 1'b1, OP_SPARE_7, KEY_MAX));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_GT, KEY_MAX));
        send_request(mk_req(KIND_START, 1'b0, OP_EQ, '0));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_LT, '0));
        send_request(mk_req(KIND_START, 1'b0, OP_EQ, '0));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_EQ, KEY_MAX));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_EQ, '0));           // conflicting point
        send_request(mk_req(KIND_START, 1'b0, OP_EQ, '0));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_GE, KEY_MAX));
        send_request(mk_req(KIND_LEAF, 1'b1, OP_LE, '0));           // crossed bounds
        wait_all_results();
    endtask

    // output held off long enough for both internal registers to fill
    task automatic test_receiver_hold();
        logic [KEY_W-1:0] base;
        send_gap_pct = 0;
        stall_pct    = 0;
        -> hold_go;
        repeat (4) begin
            base = pick_window_base();
            send_request(mk_req(KIND_START, 1'b0, OP_EQ, '0));
            repeat (7) send_request(pick_request(base));
        end
        wait_all_results();
    endtask

    task automatic test_random_predicates(input int n_req, input int tx_pct, input int rx_pct);
        int               sent;
        int               body_len;
        logic [KEY_W-1:0] base;
        send_gap_pct = tx_pct;
        stall_pct    = rx_pct;
        sent = 0;
        while (sent < n_req) begin
            if ($urandom_range(9) == 0) begin
                // unstructured noise
                send_request(mk_req(2'($urandom_range(3)), 1'($urandom_range(1)),
                                    3'($urandom_range(7)), $urandom));
                sent++;
            end else begin
                base     = pick_window_base();
                body_len = $urandom_range(8, 1);
                send_request(mk_req(KIND_START, 1'($urandom_range(1)),
                                    3'($urandom_range(7)), $urandom));
                sent++;
                repeat (body_len) begin
                    send_request(pick_request(base));
                    sent++;
                end
            end
        end
        wait_all_results();
    endtask

    initial begin
        item_ch.valid         = 1'b0;
        item_ch.kind          = KIND_START;
        item_ch.on_key_column = 1'b0;
        item_ch.compare_op    = OP_EQ;
        item_ch.operand_value = '0;
        result_ch.ready       = 1'b0;
        rst_n                 = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_receiver_hold();
        test_random_predicates(360, 0, 0);
        test_random_predicates(360, 52, 0);
        test_random_predicates(360, 0, 52);
        test_random_predicates(370, 21, 21);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_ranges.size() != 0) begin
            mismatches++;
            $error("%0d range results never arrived", expected_ranges.size());
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
